// ===== rtl/core/fba_pkg.sv =====
// Shared types and codes for the frame bitmap allocator.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned BitIdxW  = 5;

  // Result status codes
  localparam logic [2:0] STATUS_ALLOCATED  = 3'd0;
  localparam logic [2:0] STATUS_HAD_FRAME  = 3'd1;
  localparam logic [2:0] STATUS_NO_FREE    = 3'd2;
  localparam logic [2:0] STATUS_FREED      = 3'd3;
  localparam logic [2:0] STATUS_NOTHING    = 3'd4;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } fba_state_e;

  // Lowest clear bit of one bitmap word
  typedef struct packed {
    logic               found;
    logic [BitIdxW-1:0] bit_idx;
  } fba_zero_t;

endpackage

// ===== rtl/core/frame_bitmap_allocator.sv =====
// First-fit frame bitmap allocator: top level with bitmap memory and sequencer.
// Short paths: an entry that already has a frame, a free of frame 0, a free beyond the
// bitmap or an empty cover give the result in the cycle after start; a free reads its word
// in ST_FREE and answers from there; an allocation scans one bitmap word per cycle through the
// memory read port in ST_SCAN. One item at a time; busy is high meanwhile.
// Reset: a clearing pass writes zero to every bitmap word, with busy high.
// Results are a one-cycle strobe on done_o; the receiver cannot stall.
`timescale 1ns / 1ps

module frame_bitmap_allocator #(
  parameter int unsigned MAX_WORDS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [11:0] current_frame_i,
  input  logic        kernel_page_i,
  input  logic        writable_page_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        done_o,
  output logic [11:0] new_frame_o,
  output logic        present_bit_o,
  output logic        rw_bit_o,
  output logic        user_bit_o,
  output logic [2:0]  status_o,
  output logic [14:0] used_kib_o,
  output logic [14:0] total_kib_o
);
  import fba_pkg::*;

  localparam int unsigned AW      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned LimCap  = (MAX_WORDS < 128) ? MAX_WORDS : 128;

  fba_state_e state_q, state_d;

  logic [7:0]  words_q;
  logic [12:0] used_q, used_d;
  logic [6:0]  idx_q, idx_d;
  logic [4:0]  bit_q, bit_d;
  logic        kern_q, kern_d;
  logic        wr_q, wr_d;
  logic [AW-1:0] clr_q, clr_d;

  logic        done_q, done_d;
  logic [11:0] nf_q, nf_d;
  logic        pres_q, pres_d;
  logic        rw_q, rw_d;
  logic        usr_q, usr_d;
  logic [2:0]  status_q, status_d;
  logic [14:0] used_kib_q, used_kib_d;
  logic [14:0] total_kib_q;

  logic [31:0]   mem_q [MAX_WORDS];
  logic [31:0]   mem_rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [31:0]   mem_wdata;

  logic [7:0]  covered;
  logic [6:0]  req_word;
  logic        req_in_range;
  logic        scan_last;
  fba_zero_t   zero;

  assign covered      = (words_q > 8'(LimCap)) ? 8'(LimCap) : words_q;
  assign req_word     = current_frame_i[11:5];
  assign req_in_range = 32'(req_word) < 32'(MAX_WORDS);
  assign scan_last    = ({1'b0, idx_q} + 8'd1) == covered;

  fba_zero_find u_zero_find (
    .word_i (mem_rdata_q),
    .zero_o (zero)
  );

  // Bitmap memory with a registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
      words_q <= 8'd128;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        words_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    bit_q  <= bit_d;
    kern_q <= kern_d;
    wr_q   <= wr_d;
    if (done_d) begin
      nf_q        <= nf_d;
      pres_q      <= pres_d;
      rw_q        <= rw_d;
      usr_q       <= usr_d;
      status_q    <= status_d;
      used_kib_q  <= used_kib_d;
      total_kib_q <= {covered, 7'd0};
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    used_d    = used_q;
    idx_d     = idx_q;
    bit_d     = bit_q;
    kern_d    = kern_q;
    wr_d      = wr_q;
    mem_re    = 1'b0;
    mem_raddr = AW'(idx_q);
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_q);
    mem_wdata = '0;
    done_d    = 1'b0;
    nf_d      = '0;
    pres_d    = 1'b0;
    rw_d      = 1'b0;
    usr_d     = 1'b0;
    status_d  = STATUS_NO_FREE;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AW'(MAX_WORDS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          kern_d = kernel_page_i;
          wr_d   = writable_page_i;
          if (action_i == ACTION_ALLOC) begin
            if (current_frame_i != 12'd0) begin
              done_d   = 1'b1;
              nf_d     = current_frame_i;
              status_d = STATUS_HAD_FRAME;
            end else if (covered == 8'd0) begin
              done_d   = 1'b1;
              status_d = STATUS_NO_FREE;
            end else begin
              idx_d     = '0;
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = ST_SCAN;
            end
          end else begin
            if (current_frame_i == 12'd0) begin
              done_d   = 1'b1;
              status_d = STATUS_NOTHING;
            end else if (!req_in_range) begin
              done_d   = 1'b1;
              status_d = STATUS_FREED;
            end else begin
              idx_d     = req_word;
              bit_d     = current_frame_i[4:0];
              mem_re    = 1'b1;
              mem_raddr = AW'(req_word);
              state_d   = ST_FREE;
            end
          end
        end
      end
      ST_SCAN: begin
        if (zero.found) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_q | (32'd1 << zero.bit_idx);
          used_d    = used_q + 13'd1;
          done_d    = 1'b1;
          nf_d      = {idx_q, zero.bit_idx};
          pres_d    = 1'b1;
          rw_d      = wr_q;
          usr_d     = ~kern_q;
          status_d  = STATUS_ALLOCATED;
          state_d   = ST_IDLE;
        end else if (scan_last) begin
          done_d   = 1'b1;
          status_d = STATUS_NO_FREE;
          state_d  = ST_IDLE;
        end else begin
          // advance to the next word
          idx_d     = idx_q + 7'd1;
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_q + 7'd1);
        end
      end
      ST_FREE: begin
        if (mem_rdata_q[bit_q]) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_q & ~(32'd1 << bit_q);
          used_d    = used_q - 13'd1;
        end
        done_d   = 1'b1;
        status_d = STATUS_FREED;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    used_kib_d = {used_d, 2'b00};
  end

  assign busy          = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign done_o        = done_q;
  assign new_frame_o   = nf_q;
  assign present_bit_o = pres_q;
  assign rw_bit_o      = rw_q;
  assign user_bit_o    = usr_q;
  assign status_o      = status_q;
  assign used_kib_o    = used_kib_q;
  assign total_kib_o   = total_kib_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= 13'd4096)
    else $error("used frame count beyond bitmap capacity");

  a_scan_in_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, idx_q} < covered))
    else $error("scan past covered words");

  a_flags_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_ALLOCATED) |-> (!present_bit_o && !rw_bit_o && !user_bit_o))
    else $error("page bits set on a result that is not an allocation");

  a_scan_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == ACTION_ALLOC && current_frame_i == 12'd0
     && covered != 8'd0) |=> (state_q == ST_SCAN && !done_o))
    else $error("allocation did not start a scan");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_CLEAR) |=> $stable(used_q))
    else $error("used count changed outside a bitmap update");

endmodule

// ===== rtl/core/fba_zero_find.sv =====
// Finds the lowest free frame bit in one bitmap word.
`timescale 1ns / 1ps

module fba_zero_find (
  input  logic [31:0]        word_i,
  output fba_pkg::fba_zero_t zero_o
);
  import fba_pkg::*;

  always_comb begin
    zero_o.found   = 1'b0;
    zero_o.bit_idx = '0;
    // walk down so the lowest clear bit wins
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        zero_o.found   = 1'b1;
        zero_o.bit_idx = BitIdxW'(i);
      end
    end
  end

endmodule

// ===== tb/frame_bitmap_allocator_checker.sv =====
// Checker for the frame bitmap allocator: mirrors the bitmap and compares every result.
`timescale 1ns / 1ps

module frame_bitmap_allocator_checker #(
  parameter int unsigned MAX_WORDS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        action_i,
  input  logic [11:0] current_frame_i,
  input  logic        kernel_page_i,
  input  logic        writable_page_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        done_i,
  input  logic [11:0] new_frame_i,
  input  logic        present_bit_i,
  input  logic        rw_bit_i,
  input  logic        user_bit_i,
  input  logic [2:0]  status_i,
  input  logic [14:0] used_kib_i,
  input  logic [14:0] total_kib_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  import fba_pkg::*;

  typedef struct packed {
    logic [11:0] frame;
    logic        present;
    logic        rw;
    logic        user;
    logic [2:0]  status;
    logic [14:0] used_kib;
    logic [14:0] total_kib;
  } entry_update_t;

  logic [31:0]   frame_map [MAX_WORDS];
  logic [12:0]   used_frames;
  logic [7:0]    words_cfg;
  entry_update_t entry_updates_q[$];

  // A 12-bit frame number reaches only 128 words.
  function automatic int unsigned covered_words();
    int unsigned cov;
    cov = words_cfg;
    if (cov > MAX_WORDS) cov = MAX_WORDS;
    if (cov > 128) cov = 128;
    return cov;
  endfunction

  // Apply one transaction to the mirrored bitmap and return the page entry update.
  function automatic entry_update_t allocate_or_free(input logic act, input logic [11:0] cur,
                                                     input logic kern, input logic wr);
    entry_update_t upd;
    int unsigned   cov;
    int unsigned   w;
    int unsigned   b;
    logic          found;
    logic [11:0]   pick_frame;
    upd = '0;
    cov = covered_words();
    if (act == ACTION_ALLOC) begin
      if (cur != 12'd0) begin
        upd.frame  = cur;
        upd.status = STATUS_HAD_FRAME;
      end else begin
        found      = 1'b0;
        pick_frame = 12'd0;
        for (w = 0; w < cov && !found; w++) begin
          if (frame_map[w] != 32'hFFFF_FFFF) begin
            for (b = 0; b < 32 && !found; b++) begin
              if (!frame_map[w][b]) begin
                found      = 1'b1;
                pick_frame = 12'(w * 32 + b);
              end
            end
          end
        end
        if (found) begin
          frame_map[pick_frame[11:5]][pick_frame[4:0]] = 1'b1;
          used_frames  = used_frames + 13'd1;
          upd.frame    = pick_frame;
          upd.present  = 1'b1;
          upd.rw       = wr;
          upd.user     = ~kern;
          upd.status   = STATUS_ALLOCATED;
        end else begin
          upd.status = STATUS_NO_FREE;
        end
      end
    end else if (cur == 12'd0) begin
      upd.status = STATUS_NOTHING;
    end else begin
      // Frames beyond the covered words are still cleared.
      if (int'(cur[11:5]) < MAX_WORDS && frame_map[cur[11:5]][cur[4:0]]) begin
        frame_map[cur[11:5]][cur[4:0]] = 1'b0;
        used_frames = used_frames - 13'd1;
      end
      upd.status = STATUS_FREED;
    end
    upd.used_kib  = {used_frames, 2'b00};
    upd.total_kib = 15'(cov * 128);
    return upd;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      report_mismatch($sformatf("%s: expected %0d, got %0d", name, want, got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    entry_update_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WORDS; i++) frame_map[i] = '0;
      used_frames  = '0;
      words_cfg    = 8'd128;
      entry_updates_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Compare first: a new transaction may be accepted at the edge that ends a result.
      if (done_i) begin
        if (entry_updates_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, status %0d", status_i));
        end else begin
          want = entry_updates_q.pop_front();
          check_field("new_frame", want.frame, new_frame_i);
          check_field("present_bit", want.present, present_bit_i);
          check_field("rw_bit", want.rw, rw_bit_i);
          check_field("user_bit", want.user, user_bit_i);
          check_field("status", want.status, status_i);
          check_field("used_kib", want.used_kib, used_kib_i);
          check_field("total_kib", want.total_kib, total_kib_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) words_cfg = cfg_data_i;
      if (start_i && !busy_i) begin
        entry_updates_q.push_back(allocate_or_free(action_i, current_frame_i,
                                                   kernel_page_i, writable_page_i));
      end
      pending_o = entry_updates_q.size();
    end
  end

endmodule

// ===== tb/frame_bitmap_allocator_tb.sv =====
// Testbench top for the frame bitmap allocator: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module frame_bitmap_allocator_tb;

  import fba_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned NumPhases  = 8;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic        action_i        = ACTION_ALLOC;
  logic [11:0] current_frame_i = 12'd0;
  logic        kernel_page_i   = 1'b0;
  logic        writable_page_i = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i      = 8'd0;
  logic        done_o;
  logic [11:0] new_frame_o;
  logic        present_bit_o;
  logic        rw_bit_o;
  logic        user_bit_o;
  logic [2:0]  status_o;
  logic [14:0] used_kib_o;
  logic [14:0] total_kib_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count     = 0;
  int unsigned sender_idle_pct = 0;
  logic [7:0]  words_setting   = 8'd128;

  // Word settings and sender idling per random phase
  logic [7:0]  phase_words [NumPhases] = '{8'd1, 8'd3, 8'd8, 8'd255, 8'd2, 8'd0, 8'd128, 8'd6};
  int unsigned phase_idle  [NumPhases] = '{0, 47, 0, 37, 47, 0, 37, 0};
  int unsigned phase_items [NumPhases] = '{200, 220, 200, 220, 200, 160, 300, 200};

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  frame_bitmap_allocator u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .action_i,
    .current_frame_i,
    .kernel_page_i,
    .writable_page_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .done_o,
    .new_frame_o,
    .present_bit_o,
    .rw_bit_o,
    .user_bit_o,
    .status_o,
    .used_kib_o,
    .total_kib_o
  );

  frame_bitmap_allocator_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i         (start),
    .busy_i          (busy),
    .action_i,
    .current_frame_i,
    .kernel_page_i,
    .writable_page_i,
    .cfg_valid_i,
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i,
    .done_i          (done_o),
    .new_frame_i     (new_frame_o),
    .present_bit_i   (present_bit_o),
    .rw_bit_i        (rw_bit_o),
    .user_bit_i      (user_bit_o),
    .status_i        (status_o),
    .used_kib_i      (used_kib_o),
    .total_kib_i     (total_kib_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance, start still high.
  task automatic drive_item(input logic act, input logic [11:0] cur, input logic kern,
                            input logic wr);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start           <= 1'b1;
    action_i        <= act;
    current_frame_i <= cur;
    kernel_page_i   <= kern;
    writable_page_i <= wr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop start, let the block go idle, then write the word count.
  task automatic next_setting(input logic [7:0] value);
    start <= 1'b0;
    wait_drained();
    cfg_valid_i   <= 1'b1;
    cfg_data_i    <= value;
    words_setting  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly frames near the covered range so frees hit marked frames.
  task automatic random_item();
    logic        act;
    logic [11:0] cur;
    int unsigned sel;
    int unsigned span;
    span = ((words_setting > 128) ? 128 : words_setting) * 32 + 32;
    if (span > 4096) span = 4096;
    act = ($urandom_range(99) < 55) ? ACTION_ALLOC : ACTION_FREE;
    sel = $urandom_range(99);
    if (act == ACTION_ALLOC) begin
      cur = (sel < 75) ? 12'd0 : 12'($urandom);
    end else if (sel < 10) begin
      cur = 12'd0;
    end else if (sel < 60) begin
      cur = 12'($urandom_range(span - 1));
    end else if (sel < 85) begin
      cur = 12'($urandom_range(511));
    end else begin
      cur = 12'($urandom);
    end
    drive_item(act, cur, 1'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty cover: nothing to hand out, total is zero
    next_setting(8'd0);
    drive_item(ACTION_ALLOC, 12'd0, 1'b0, 1'b1);
    drive_item(ACTION_FREE, 12'd0, 1'b1, 1'b0);
    drive_item(ACTION_FREE, 12'd4095, 1'b1, 1'b1);

    next_setting(8'd1);
    drive_item(ACTION_ALLOC, 12'd0, 1'b1, 1'b0);     // hands out frame zero
    drive_item(ACTION_ALLOC, 12'd0, 1'b0, 1'b1);
    drive_item(ACTION_ALLOC, 12'd4095, 1'b1, 1'b1);  // entry keeps its frame
    drive_item(ACTION_ALLOC, 12'd1, 1'b0, 1'b0);
    drive_item(ACTION_FREE, 12'd0, 1'b0, 1'b0);
    drive_item(ACTION_FREE, 12'd1, 1'b0, 1'b1);
    drive_item(ACTION_FREE, 12'd1, 1'b1, 1'b0);      // already free
    drive_item(ACTION_ALLOC, 12'd0, 1'b0, 1'b0);
    drive_item(ACTION_ALLOC, 12'd0, 1'b1, 1'b1);
    drive_item(ACTION_FREE, 12'd4095, 1'b0, 1'b0);
    drive_item(ACTION_FREE, 12'd100, 1'b1, 1'b1);    // beyond the covered words

    for (int p = 0; p < NumPhases; p++) begin
      next_setting(phase_words[p]);
      sender_idle_pct = phase_idle[p];
      for (int n = 0; n < phase_items[p]; n++) random_item();
    end

    start <= 1'b0;
    wait_drained();
    repeat (140) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/fba_pkg.sv
rtl/core/fba_zero_find.sv
rtl/core/frame_bitmap_allocator.sv
tb/frame_bitmap_allocator_checker.sv
tb/frame_bitmap_allocator_tb.sv
